@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the scaler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define BIR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("scaler assertion failed");

// Checked at every edge, reset included.
`define BIR_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("scaler reset assertion failed");

`endif

@@ design/bir_pkg.sv @@
// Shared types and constants of the bilinear image scaler.
package bir_pkg;

  localparam int APB_ADDR_W = 5;
  localparam int COORD_W    = 12;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SRC_REG_W  = 9;
  localparam int DST_REG_W  = 13;
  localparam int IDX_W      = SRC_REG_W;
  // (2*pos+1)*src, a 13-bit odd number times a 9-bit size
  localparam int A_W        = COORD_W + 1 + SRC_REG_W;
  localparam int FRAC_PAD   = 15;
  localparam int DIV_W      = A_W + FRAC_PAD;
  localparam int FRAC_W     = 16;
  localparam int WT_W       = 2 * FRAC_W + 1;
  localparam int HALF_Q16   = 32768;
  localparam int ONE_Q16    = 65536;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT,
    REG_INTERP_MODE
  } reg_idx_t;

  localparam logic MODE_NEAREST = 1'b0;
  localparam logic ACT_LOAD     = 1'b0;

  // Item data that rides along the pipeline
  typedef struct packed {
    logic               query;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pix;
  } sb_t;

  // Neighbor indices and fraction along one axis
  typedef struct packed {
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    logic [FRAC_W-1:0] f;
  } axis_t;

endpackage

@@ design/bir_if.sv @@
// Stream interfaces of the scaler: query/load beats in, pixel beats out.
interface bir_in_if;
  import bir_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [COORD_W-1:0] pos_col;
  logic [COORD_W-1:0] pos_row;
  logic [CH_W-1:0]    in_red;
  logic [CH_W-1:0]    in_green;
  logic [CH_W-1:0]    in_blue;

  modport source (output valid, action, pos_col, pos_row, in_red, in_green, in_blue,
                  input ready);
  modport sink   (input valid, action, pos_col, pos_row, in_red, in_green, in_blue,
                  output ready);
endinterface

interface bir_out_if;
  import bir_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic [CH_W-1:0]    out_red;
  logic [CH_W-1:0]    out_green;
  logic [CH_W-1:0]    out_blue;

  modport source (output valid, out_col, out_row, out_red, out_green, out_blue,
                  input ready);
  modport sink   (input valid, out_col, out_row, out_red, out_green, out_blue,
                  output ready);
endinterface

@@ design/bilinear_image_resize_unit.sv @@
// Top level of the bilinear image scaler over a banked source frame store.
//
//   port group  dir  handshake            beat
//   in_ch       in   valid/ready          load pixel or query destination pixel
//   out_ch      out  valid/ready          one resampled RGB pixel per query
//   psel ...    in   APB, pready tied 1   size and mode registers
//
// One beat per clock while not stalled. A query walks the capture stage, the
// per-axis dividers, index, bank, product stages and the output register.
// Loads walk the same pipeline and write the store in the bank stage, so a
// query issued after a load sees it. Four parity banks serve four neighbors.
// Reset (sync, active low) clears valid bits and presets the APB registers only.
// The pipeline stalls only when a result waits unread and another is ready.
module bilinear_image_resize_unit #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bir_in_if.sink                          in_ch,
  bir_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bir_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import bir_pkg::*;

  localparam int POS_C  = DIV_W + 1;
  localparam int POS_M  = DIV_W + 2;
  localparam int POS_P  = DIV_W + 3;
  localparam int NST    = DIV_W + 4;
  localparam int BANK_W = (MAX_SRC_WIDTH + 1) / 2;
  localparam int BANK_H = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int BANK_D = BANK_W * BANK_H;
  localparam int BAW    = (BANK_D > 1) ? $clog2(BANK_D) : 1;

  // ---------------- configuration ----------------
  logic [SRC_REG_W-1:0] src_w_r, src_h_r;
  logic [DST_REG_W-1:0] dst_w_r, dst_h_r;
  logic                 mode_r;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SRC_REG_W'(256);
      src_h_r <= SRC_REG_W'(256);
      dst_w_r <= DST_REG_W'(256);
      dst_h_r <= DST_REG_W'(256);
      mode_r  <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SRC_WIDTH:   src_w_r <= pwdata[SRC_REG_W-1:0];
        REG_SRC_HEIGHT:  src_h_r <= pwdata[SRC_REG_W-1:0];
        REG_DST_WIDTH:   dst_w_r <= pwdata[DST_REG_W-1:0];
        REG_DST_HEIGHT:  dst_h_r <= pwdata[DST_REG_W-1:0];
        REG_INTERP_MODE: mode_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SRC_WIDTH:   prdata = 32'(src_w_r);
      REG_SRC_HEIGHT:  prdata = 32'(src_h_r);
      REG_DST_WIDTH:   prdata = 32'(dst_w_r);
      REG_DST_HEIGHT:  prdata = 32'(dst_h_r);
      REG_INTERP_MODE: prdata = 32'(mode_r);
      default:         prdata = '0;
    endcase
  end

  // effective sizes: zero reads as one, source capped at the store size
  logic [IDX_W-1:0]     sw_eff, sh_eff;
  logic [DST_REG_W-1:0] dw_eff, dh_eff;

  always_comb begin
    sw_eff = (src_w_r == '0) ? IDX_W'(1) :
             (32'(src_w_r) > MAX_SRC_WIDTH) ? IDX_W'(MAX_SRC_WIDTH) : src_w_r;
    sh_eff = (src_h_r == '0) ? IDX_W'(1) :
             (32'(src_h_r) > MAX_SRC_HEIGHT) ? IDX_W'(MAX_SRC_HEIGHT) : src_h_r;
    dw_eff = (dst_w_r == '0) ? DST_REG_W'(1) : dst_w_r;
    dh_eff = (dst_h_r == '0) ? DST_REG_W'(1) : dst_h_r;
  end

  // ---------------- pipeline control ----------------
  logic          en;
  logic          vld_r [NST];
  sb_t           sb_r  [NST];
  logic          out_valid_r;

  assign en          = !(vld_r[POS_P] && sb_r[POS_P].query) || !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k < NST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // stage 0: capture beat and form (2*pos+1)*src per axis
  logic [A_W-1:0] ax_r, ay_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0].query <= (in_ch.action != ACT_LOAD);
      sb_r[0].col   <= in_ch.pos_col;
      sb_r[0].row   <= in_ch.pos_row;
      sb_r[0].pix   <= {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
      ax_r <= A_W'({in_ch.pos_col, 1'b1}) * A_W'(sw_eff);
      ay_r <= A_W'({in_ch.pos_row, 1'b1}) * A_W'(sh_eff);
      for (int k = 1; k < NST; k++) sb_r[k] <= sb_r[k-1];
    end
  end

  // divider lanes: D = floor(A*32768/dst); source coordinate q = D - 0.5
  logic [DIV_W-1:0] qx, qy;

  bir_div_lane #(.NUM_W(DIV_W), .DEN_W(DST_REG_W)) u_div_x (
    .clk(clk), .en(en), .num_i({ax_r, FRAC_PAD'(0)}), .den_i(dw_eff), .quo_o(qx)
  );
  bir_div_lane #(.NUM_W(DIV_W), .DEN_W(DST_REG_W)) u_div_y (
    .clk(clk), .en(en), .num_i({ay_r, FRAC_PAD'(0)}), .den_i(dh_eff), .quo_o(qy)
  );

  // neighbor indices, clamped to the source edge; nearest uses one tap at weight one
  function automatic axis_t axis_map(input logic [DIV_W-1:0] quo,
                                     input logic [IDX_W-1:0] sz,
                                     input logic mode);
    logic signed [DIV_W:0]          e;
    logic signed [DIV_W-FRAC_W:0]   i0, i1, lim_s;
    logic [IDX_W-1:0]               lim;
    logic [DIV_W-FRAC_W-1:0]        n;
    axis_t                          r;
    lim   = sz - 1'b1;
    lim_s = $signed((DIV_W-FRAC_W+1)'(lim));
    e     = $signed({1'b0, quo}) - $signed((DIV_W+1)'(HALF_Q16));
    i0    = e[DIV_W:FRAC_W];
    i1    = i0 + $signed((DIV_W-FRAC_W+1)'(1));
    n     = quo[DIV_W-1:FRAC_W];
    if (mode == MODE_NEAREST) begin
      // round half away from zero of q is D >> 16; negative q lands on zero
      r.a = (n > (DIV_W-FRAC_W)'(lim)) ? lim : n[IDX_W-1:0];
      r.b = r.a;
      r.f = '0;
    end else begin
      r.a = (i0 < 0) ? '0 : (i0 > lim_s) ? lim : i0[IDX_W-1:0];
      r.b = (i1 < 0) ? '0 : (i1 > lim_s) ? lim : i1[IDX_W-1:0];
      r.f = e[FRAC_W-1:0];
    end
    return r;
  endfunction

  axis_t xs_r, ys_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r <= axis_map(qx, sw_eff, mode_r);
      ys_r <= axis_map(qy, sh_eff, mode_r);
    end
  end

  // ---------------- bank stage ----------------
  function automatic logic [BAW-1:0] bank_addr(input logic [COORD_W-1:0] c,
                                               input logic [COORD_W-1:0] r);
    logic [2*COORD_W-1:0] lin;
    lin = (2*COORD_W)'(r[COORD_W-1:1]) * (2*COORD_W)'(BANK_W) +
          (2*COORD_W)'(c[COORD_W-1:1]);
    return lin[BAW-1:0];
  endfunction

  logic             ld_ok;
  logic [PIX_W-1:0] rd_r [4];

  assign ld_ok = vld_r[POS_C] && !sb_r[POS_C].query &&
                 (32'(sb_r[POS_C].col) < MAX_SRC_WIDTH) &&
                 (32'(sb_r[POS_C].row) < MAX_SRC_HEIGHT);

  // bank index: bit 1 row parity, bit 0 column parity
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0]   mem [BANK_D];
    logic               we;
    logic [IDX_W-1:0]   csel, rsel;
    logic [BAW-1:0]     wa, ra;

    assign we   = ld_ok && (sb_r[POS_C].row[0] == b[1]) && (sb_r[POS_C].col[0] == b[0]);
    assign csel = (xs_r.a[0] == b[0]) ? xs_r.a : xs_r.b;
    assign rsel = (ys_r.a[0] == b[1]) ? ys_r.a : ys_r.b;
    assign wa   = bank_addr(sb_r[POS_C].col, sb_r[POS_C].row);
    assign ra   = bank_addr(COORD_W'(csel), COORD_W'(rsel));

    always_ff @(posedge clk) begin
      if (en) begin
        if (we) mem[wa] <= sb_r[POS_C].pix;
        rd_r[b] <= mem[ra];
      end
    end
  end

  // weights in Q1.32, order p00 p10 p01 p11
  logic [FRAC_W:0]       wx0, wx1, wy0, wy1;
  logic [2*FRAC_W+1:0]   wp [4];
  logic [3:0][WT_W-1:0]  w_r;
  logic                  xa0_r, xb0_r, ya0_r, yb0_r;

  always_comb begin
    wx0   = (FRAC_W+1)'(ONE_Q16) - (FRAC_W+1)'(xs_r.f);
    wx1   = (FRAC_W+1)'(xs_r.f);
    wy0   = (FRAC_W+1)'(ONE_Q16) - (FRAC_W+1)'(ys_r.f);
    wy1   = (FRAC_W+1)'(ys_r.f);
    wp[0] = (2*FRAC_W+2)'(wx0) * (2*FRAC_W+2)'(wy0);
    wp[1] = (2*FRAC_W+2)'(wx1) * (2*FRAC_W+2)'(wy0);
    wp[2] = (2*FRAC_W+2)'(wx0) * (2*FRAC_W+2)'(wy1);
    wp[3] = (2*FRAC_W+2)'(wx1) * (2*FRAC_W+2)'(wy1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) w_r[k] <= wp[k][WT_W-1:0];
      xa0_r <= xs_r.a[0];
      xb0_r <= xs_r.b[0];
      ya0_r <= ys_r.a[0];
      yb0_r <= ys_r.b[0];
    end
  end

  // merge: route each bank to its neighbor slot
  logic [3:0][PIX_W-1:0] nb;

  always_comb begin
    nb[0] = rd_r[{ya0_r, xa0_r}];
    nb[1] = rd_r[{ya0_r, xb0_r}];
    nb[2] = rd_r[{yb0_r, xa0_r}];
    nb[3] = rd_r[{yb0_r, xb0_r}];
  end

  logic [CH_W-1:0] ch [3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic [3:0][CH_W-1:0] lane_pix;
    for (genvar k = 0; k < 4; k++) begin : g_tap
      assign lane_pix[k] = nb[k][PIX_W-1-CH_W*g -: CH_W];
    end
    bir_blend_lane u_lane (
      .clk(clk), .en(en), .pix_i(lane_pix), .wt_i(w_r), .ch_o(ch[g])
    );
  end

  // ---------------- output register ----------------
  logic [COORD_W-1:0] ocol_r, orow_r;
  logic [CH_W-1:0]    ored_r, ogrn_r, oblu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && vld_r[POS_P] && sb_r[POS_P].query) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[POS_P] && sb_r[POS_P].query) begin
      ocol_r <= sb_r[POS_P].col;
      orow_r <= sb_r[POS_P].row;
      ored_r <= ch[0];
      ogrn_r <= ch[1];
      oblu_r <= ch[2];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_col   = ocol_r;
  assign out_ch.out_row   = orow_r;
  assign out_ch.out_red   = ored_r;
  assign out_ch.out_green = ogrn_r;
  assign out_ch.out_blue  = oblu_r;

endmodule

@@ design/bir_div_lane.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module bir_div_lane #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];
  logic [NUM_W-1:0] quo_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
        num_r[k] <= {num_in[NUM_W-2:0], 1'b0};
        quo_r[k] <= {quo_in[NUM_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_r[NUM_W-1];

endmodule

@@ design/bir_blend_lane.sv @@
// One color channel: weighted sum of four neighbors, round and saturate.
module bir_blend_lane (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [3:0][bir_pkg::CH_W-1:0]           pix_i,
  input  logic [3:0][bir_pkg::WT_W-1:0]           wt_i,
  output logic [bir_pkg::CH_W-1:0]                ch_o
);
  import bir_pkg::*;

  localparam int PROD_W = CH_W + WT_W;
  localparam int SUM_W  = PROD_W + 2;

  logic [PROD_W-1:0] prod_r [4];
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-33:0] val;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= PROD_W'(pix_i[k]) * PROD_W'(wt_i[k]);
      end
    end
  end

  always_comb begin
    sum = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]) +
          SUM_W'(prod_r[3]) + (SUM_W'(1) << 31);
    val = sum[SUM_W-1:32];
    ch_o = (val > (SUM_W-32)'(255)) ? {CH_W{1'b1}} : val[CH_W-1:0];
  end

endmodule

@@ design/bir_checker.sv @@
// Port-level checks of the scaler and their binding to the top level.
`include "assert_macros.svh"

module bir_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bir_pkg::COORD_W-1:0]    out_col,
  input logic [bir_pkg::COORD_W-1:0]    out_row,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [bir_pkg::APB_ADDR_W-1:0] paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata
);
  import bir_pkg::*;

  localparam logic [APB_ADDR_W-1:0] ADDR_SRC_W = {REG_SRC_WIDTH, 2'b00};

  logic src_w_wr;
  logic in_seen;

  assign src_w_wr = psel && penable && pwrite && (paddr == ADDR_SRC_W);
  assign in_seen  = in_valid || !in_valid;

  `BIR_ASSERT_RST(a_reset_clears_out, clk, !rst_n |=> !out_valid)
  `BIR_ASSERT(a_in_open_when_out_empty, clk, rst_n, in_seen && !out_valid |-> in_ready)
  `BIR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_col) && $stable(out_row))
  `BIR_ASSERT(a_src_w_readback, clk, rst_n, src_w_wr ##1 (paddr == ADDR_SRC_W) |-> prdata[8:0] == $past(pwdata[8:0]))

endmodule

bind bilinear_image_resize_unit bir_checker u_bir_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_col(out_ch.out_col), .out_row(out_ch.out_row),
  .psel(psel), .penable(penable), .pwrite(pwrite),
  .paddr(paddr), .pwdata(pwdata), .prdata(prdata)
);
